// ===== rtl/core/swp_pkg.sv =====
package swp_pkg;

	localparam int MAP_SIZE = 2048;

	// squared distance, Q.16, inside the brush it stays below 2^38
	localparam int D2_W     = 38;
	localparam int SQ_FRAC  = 16;
	localparam int SQ_N     = (D2_W + SQ_FRAC) / 2;
	// normalized distance quotient bits
	localparam int TQ_W     = 17;
	// sphere falloff root bits
	localparam int FS_N     = 17;
	// layer rescale quotient bits
	localparam int BQ_W     = 9;

	localparam logic [16:0] Q16_ONE    = 17'd65536;
	localparam logic [14:0] K035       = 15'd22938;
	localparam logic [18:0] RADIUS_MIN = 19'd256;

	typedef enum logic [1:0] {
		FALL_SMOOTH,
		FALL_LINEAR,
		FALL_SPHERE,
		FALL_SHARP
	} falloff_e;

	typedef enum logic [2:0] {
		CFG_CENTER_X,
		CFG_CENTER_Z,
		CFG_RADIUS,
		CFG_STRENGTH,
		CFG_LAYER,
		CFG_FALLOFF
	} cfg_idx_e;

	typedef struct packed {
		logic [18:0] center_x;
		logic [18:0] center_z;
		logic [18:0] radius;
		logic [16:0] strength;
		logic [1:0]  layer;
		falloff_e    falloff;
	} cfg_t;

	typedef struct packed {
		logic [3:0][7:0] wt;
		logic            cand;
	} pay_t;

	typedef struct packed {
		logic [3:0][7:0] wt;
		logic            touched;
	} res_t;

	typedef struct packed {
		logic [SQ_N+1:0] rem;
		logic [SQ_N-1:0] root;
	} sq_t;

	// one digit of a square root, two radicand bits in
	function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
		logic [SQ_N+1:0] sh;
		logic [SQ_N+1:0] trial;
		sq_t             nxt;
		sh    = {cur.rem[SQ_N-1:0], pair};
		trial = {cur.root, 2'b01};
		if (sh >= trial) begin
			nxt.rem  = sh - trial;
			nxt.root = {cur.root[SQ_N-2:0], 1'b1};
		end else begin
			nxt.rem  = sh;
			nxt.root = {cur.root[SQ_N-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ===== rtl/core/swp_if.sv =====
interface swp_texel_if;
	logic        valid;
	logic        ready;
	logic [10:0] texel_x;
	logic [10:0] texel_z;
	logic [7:0]  in_weight0;
	logic [7:0]  in_weight1;
	logic [7:0]  in_weight2;
	logic [7:0]  in_weight3;

	modport source (output valid, texel_x, texel_z, in_weight0, in_weight1, in_weight2,
		in_weight3, input ready);
	modport sink (input valid, texel_x, texel_z, in_weight0, in_weight1, in_weight2,
		in_weight3, output ready);
endinterface

interface swp_paint_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_weight0;
	logic [7:0] out_weight1;
	logic [7:0] out_weight2;
	logic [7:0] out_weight3;
	logic       touched;

	modport source (output valid, out_weight0, out_weight1, out_weight2, out_weight3,
		touched, input ready);
	modport sink (input valid, out_weight0, out_weight1, out_weight2, out_weight3,
		touched, output ready);
endinterface

// ===== rtl/core/splat_weight_paint_core.sv =====
// Throughput: one texel per cycle; every stage advances together and the
// whole pipe holds while a finished result waits to be taken.
// Reset: arst_n clears all valid bits and loads the brush registers with their
// defaults (centre 0, radius one texel, full strength, layer 0, smooth).
module splat_weight_paint_core import swp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_wdata,
	swp_texel_if.sink   texel,
	swp_paint_if.source paint
);

	logic [18:0] center_x_q, center_z_q, radius_q;
	logic [16:0] strength_q;
	logic [1:0]  layer_q;
	falloff_e    falloff_q;
	cfg_t        cfg;

	logic            adv;
	pay_t            in_pay;
	logic            t_v, w_v, res_v;
	logic [TQ_W-1:0] t_q;
	logic [14:0]     w;
	pay_t            t_pay, w_pay;
	res_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_z_q <= '0;
			radius_q   <= RADIUS_MIN;
			strength_q <= Q16_ONE;
			layer_q    <= '0;
			falloff_q  <= FALL_SMOOTH;
		end else if (cfg_we) begin
			case (cfg_idx_e'(cfg_index))
				CFG_CENTER_X: center_x_q <= cfg_wdata;
				CFG_CENTER_Z: center_z_q <= cfg_wdata;
				CFG_RADIUS:   radius_q   <= cfg_wdata;
				CFG_STRENGTH: strength_q <= cfg_wdata[16:0];
				CFG_LAYER:    layer_q    <= cfg_wdata[1:0];
				CFG_FALLOFF:  falloff_q  <= falloff_e'(cfg_wdata[1:0]);
				default:      ;
			endcase
		end
	end

	always_comb begin
		cfg.center_x = center_x_q;
		cfg.center_z = center_z_q;
		cfg.radius   = (radius_q < RADIUS_MIN) ? RADIUS_MIN : radius_q;
		cfg.strength = (strength_q > Q16_ONE) ? Q16_ONE : strength_q;
		cfg.layer    = layer_q;
		cfg.falloff  = falloff_q;
	end

	// advance whenever the output register is free or being drained
	assign adv         = !res_v || paint.ready;
	assign texel.ready = adv;

	assign in_pay.wt   = {texel.in_weight3, texel.in_weight2, texel.in_weight1, texel.in_weight0};
	assign in_pay.cand = 1'b1;

	swp_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cfg     (cfg),
		.in_v    (texel.valid),
		.texel_x (texel.texel_x),
		.texel_z (texel.texel_z),
		.in_pay  (in_pay),
		.t_v     (t_v),
		.t_q     (t_q),
		.t_pay   (t_pay)
	);

	swp_falloff u_falloff (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.t_v    (t_v),
		.t_q    (t_q),
		.t_pay  (t_pay),
		.w_v    (w_v),
		.w      (w),
		.w_pay  (w_pay)
	);

	swp_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg),
		.w_v    (w_v),
		.w      (w),
		.w_pay  (w_pay),
		.res_v  (res_v),
		.res    (res)
	);

	assign paint.valid       = res_v;
	assign paint.out_weight0 = res.wt[0];
	assign paint.out_weight1 = res.wt[1];
	assign paint.out_weight2 = res.wt[2];
	assign paint.out_weight3 = res.wt[3];
	assign paint.touched     = res.touched;

endmodule

// ===== rtl/core/swp_dist.sv =====
module swp_dist import swp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  cfg_t        cfg,
	input  logic        in_v,
	input  logic [10:0] texel_x,
	input  logic [10:0] texel_z,
	input  pay_t        in_pay,
	output logic        t_v,
	output logic [TQ_W-1:0] t_q,
	output pay_t        t_pay
);

	logic               v_s1, v_s2;
	logic signed [19:0] dx_s1, dz_s1;
	pay_t               pay_s1, pay_s2;
	logic [D2_W-1:0]    sqx_s2, sqz_s2, rr_s2;

	logic signed [39:0] sqx, sqz;
	logic [D2_W-1:0]    rr;
	logic [D2_W:0]      d2;
	logic               onmap;

	// sqrt chain, element 0 is the compare stage
	logic            sq_v_s   [SQ_N+1];
	sq_t             sq_s     [SQ_N+1];
	logic [D2_W-1:0] sq_rad_s [SQ_N+1];
	pay_t            sq_pay_s [SQ_N+1];

	// divide chain
	logic            dv_v_s   [TQ_W];
	logic [18:0]     dv_rem_s [TQ_W];
	logic [TQ_W-1:0] dv_num_s [TQ_W];
	logic [TQ_W-1:0] dv_q_s   [TQ_W];
	pay_t            dv_pay_s [TQ_W];

	assign onmap = (32'(texel_x) < 32'(MAP_SIZE)) && (32'(texel_z) < 32'(MAP_SIZE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_v;
			v_s2      <= v_s1;
			sq_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= $signed({1'b0, texel_x, 8'd0}) - $signed({1'b0, cfg.center_x});
			dz_s1  <= $signed({1'b0, texel_z, 8'd0}) - $signed({1'b0, cfg.center_z});
			pay_s1 <= '{wt: in_pay.wt, cand: in_pay.cand && onmap};
		end
	end

	assign sqx = dx_s1 * dx_s1;
	assign sqz = dz_s1 * dz_s1;
	assign rr  = cfg.radius * cfg.radius;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= sqx[D2_W-1:0];
			sqz_s2 <= sqz[D2_W-1:0];
			rr_s2  <= rr;
			pay_s2 <= pay_s1;
		end
	end

	assign d2 = {1'b0, sqx_s2} + {1'b0, sqz_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0]     <= '0;
			sq_rad_s[0] <= d2[D2_W-1:0];
			sq_pay_s[0] <= '{wt: pay_s2.wt, cand: pay_s2.cand && (d2 <= {1'b0, rr_s2})};
		end
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic [2*SQ_N-1:0] radf;
		sq_t               nxt;

		assign radf = {sq_rad_s[k], {SQ_FRAC{1'b0}}};
		assign nxt  = sqrt_step(sq_s[k], radf[2*SQ_N-1-2*k -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1]     <= nxt;
				sq_rad_s[k+1] <= sq_rad_s[k];
				sq_pay_s[k+1] <= sq_pay_s[k];
			end
		end
	end

	// (s << 8) / radius, quotient below 2^17 inside the brush
	for (genvar k = 0; k < TQ_W; k++) begin : g_div
		logic            v_in;
		logic [18:0]     rem_in;
		logic [TQ_W-1:0] num_in;
		logic [TQ_W-1:0] q_in;
		pay_t            pay_in;
		logic [19:0]     sh;
		logic            take;

		if (k == 0) begin : g_first
			assign v_in   = sq_v_s[SQ_N];
			assign rem_in = {1'b0, sq_s[SQ_N].root[SQ_N-1:TQ_W-8]};
			assign num_in = {sq_s[SQ_N].root[TQ_W-9:0], 8'd0};
			assign q_in   = '0;
			assign pay_in = sq_pay_s[SQ_N];
		end else begin : g_next
			assign v_in   = dv_v_s[k-1];
			assign rem_in = dv_rem_s[k-1];
			assign num_in = dv_num_s[k-1];
			assign q_in   = dv_q_s[k-1];
			assign pay_in = dv_pay_s[k-1];
		end

		assign sh   = {rem_in, num_in[TQ_W-1-k]};
		assign take = sh >= {1'b0, cfg.radius};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[k] <= take ? 19'(sh - {1'b0, cfg.radius}) : sh[18:0];
				dv_num_s[k] <= num_in;
				dv_q_s[k]   <= q_in | (TQ_W'(take) << (TQ_W-1-k));
				dv_pay_s[k] <= pay_in;
			end
		end
	end

	assign t_v   = dv_v_s[TQ_W-1];
	assign t_q   = dv_q_s[TQ_W-1];
	assign t_pay = dv_pay_s[TQ_W-1];

endmodule

// ===== rtl/core/swp_falloff.sv =====
module swp_falloff import swp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  cfg_t            cfg,
	input  logic            t_v,
	input  logic [TQ_W-1:0] t_q,
	input  pay_t            t_pay,
	output logic            w_v,
	output logic [14:0]     w,
	output pay_t            w_pay
);

	logic [16:0] t_c, u_c;
	logic [33:0] ttp, uup;

	logic        v_s1, v_s2, v_s4, v_s5, v_s6;
	logic [16:0] t_s1, u_s1, u_s2, sharp_s2;
	logic [32:0] tt_s1, uu_s1, sph_s2;
	logic [48:0] num_s2;
	falloff_e    mode_s2;
	pay_t        pay_s1, pay_s2, pay_s4, pay_s5, pay_s6;
	logic [16:0] f_s4;
	logic [32:0] fs_s5;
	logic [14:0] w_s6;

	logic [17:0] kk;
	logic [50:0] nump;
	logic [33:0] shs;
	logic [49:0] smr;
	logic [16:0] fns;
	logic [33:0] fsp;
	logic [47:0] wp;

	// sphere sqrt chain, element 0 is the entry stage
	logic          fs_v_s    [FS_N+1];
	logic [FS_N+1:0] fs_rem_s [FS_N+1];
	logic [FS_N-1:0] fs_root_s [FS_N+1];
	logic [32:0]   fs_arg_s  [FS_N+1];
	logic [16:0]   fs_fns_s  [FS_N+1];
	logic          fs_sph_s  [FS_N+1];
	pay_t          fs_pay_s  [FS_N+1];

	assign t_c = (t_q > Q16_ONE) ? Q16_ONE : t_q;
	assign u_c = Q16_ONE - t_c;
	assign ttp = t_c * t_c;
	assign uup = u_c * u_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			fs_v_s[0] <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
		end else if (adv) begin
			v_s1      <= t_v;
			v_s2      <= v_s1;
			fs_v_s[0] <= v_s2;
			v_s4      <= fs_v_s[FS_N];
			v_s5      <= v_s4;
			v_s6      <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1   <= t_c;
			u_s1   <= u_c;
			tt_s1  <= ttp[32:0];
			uu_s1  <= uup[32:0];
			pay_s1 <= t_pay;
		end
	end

	assign kk   = 18'd196608 - {t_s1, 1'b0};
	assign nump = tt_s1 * kk;
	assign shs  = {1'b0, uu_s1} + 34'h8000;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2   <= nump[48:0];
			sph_s2   <= 33'h1_0000_0000 - tt_s1;
			sharp_s2 <= shs[32:16];
			u_s2     <= u_s1;
			mode_s2  <= cfg.falloff;
			pay_s2   <= pay_s1;
		end
	end

	assign smr = {1'b0, num_s2} + 50'h8000_0000;

	always_comb begin
		case (mode_s2)
			FALL_SMOOTH: fns = 17'(Q16_ONE - smr[48:32]);
			FALL_LINEAR: fns = u_s2;
			FALL_SHARP:  fns = sharp_s2;
			default:     fns = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fs_rem_s[0]  <= '0;
			fs_root_s[0] <= '0;
			fs_arg_s[0]  <= sph_s2;
			fs_fns_s[0]  <= fns;
			fs_sph_s[0]  <= (mode_s2 == FALL_SPHERE);
			fs_pay_s[0]  <= pay_s2;
		end
	end

	for (genvar k = 0; k < FS_N; k++) begin : g_sph
		logic [2*FS_N-1:0] argf;
		sq_t               cur, nxt;

		assign argf     = {1'b0, fs_arg_s[k]};
		assign cur.rem  = (SQ_N+2)'(fs_rem_s[k]);
		assign cur.root = SQ_N'(fs_root_s[k]);
		assign nxt      = sqrt_step(cur, argf[2*FS_N-1-2*k -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fs_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				fs_v_s[k+1] <= fs_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fs_rem_s[k+1]  <= nxt.rem[FS_N+1:0];
				fs_root_s[k+1] <= nxt.root[FS_N-1:0];
				fs_arg_s[k+1]  <= fs_arg_s[k];
				fs_fns_s[k+1]  <= fs_fns_s[k];
				fs_sph_s[k+1]  <= fs_sph_s[k];
				fs_pay_s[k+1]  <= fs_pay_s[k];
			end
		end
	end

	assign fsp = f_s4 * cfg.strength;
	assign wp  = fs_s5 * K035 + 48'h8000_0000;

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s4   <= fs_sph_s[FS_N] ? fs_root_s[FS_N] : fs_fns_s[FS_N];
			pay_s4 <= fs_pay_s[FS_N];
			fs_s5  <= fsp[32:0];
			pay_s5 <= pay_s4;
			w_s6   <= wp[46:32];
			pay_s6 <= pay_s5;
		end
	end

	assign w_v   = v_s6;
	assign w     = w_s6;
	assign w_pay = pay_s6;

endmodule

// ===== rtl/core/swp_blend.sv =====
module swp_blend import swp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  cfg_t        cfg,
	input  logic        w_v,
	input  logic [14:0] w,
	input  pay_t        w_pay,
	output logic        res_v,
	output res_t        res
);

	logic [7:0]       wl;
	logic [9:0]       total;
	logic [2:0][7:0]  ow;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [7:0]       wl_s1;
	logic [9:0]       o_s1, o_s2, o_s3;
	logic [2:0][7:0]  ow_s1, ow_s2;
	logic [14:0]      w_s1;
	logic [1:0]       lay_s1, lay_s2, lay_s3;
	logic             tch_s1, tch_s2, tch_s3;
	logic [3:0][7:0]  wt_s1, wt_s2, wt_s3;
	logic [23:0]      tgt_s2;
	logic [2:0][16:0] m_s3;
	res_t             res_s4;

	logic [24:0]      tgtp;

	logic            bd_v_s   [BQ_W];
	logic [2:0][9:0] bd_rem_s [BQ_W];
	logic [2:0][8:0] bd_num_s [BQ_W];
	logic [2:0][8:0] bd_q_s   [BQ_W];
	logic [9:0]      bd_o_s   [BQ_W];
	logic [1:0]      bd_lay_s [BQ_W];
	logic            bd_tch_s [BQ_W];
	logic [3:0][7:0] bd_wt_s  [BQ_W];

	always_comb begin
		wl    = w_pay.wt[cfg.layer];
		total = 10'(w_pay.wt[0]) + 10'(w_pay.wt[1]) + 10'(w_pay.wt[2]) + 10'(w_pay.wt[3]);
		for (int j = 0; j < 3; j++) begin
			ow[j] = (2'(j) < cfg.layer) ? w_pay.wt[2'(j)] : w_pay.wt[2'(j + 1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= w_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= bd_v_s[BQ_W-1];
		end
	end

	assign tgtp = (8'd255 - wl_s1) * (Q16_ONE - {2'b00, w_s1});

	always_ff @(posedge clk) begin
		if (adv) begin
			wl_s1  <= wl;
			o_s1   <= total - 10'(wl);
			ow_s1  <= ow;
			w_s1   <= w;
			lay_s1 <= cfg.layer;
			tch_s1 <= w_pay.cand && (w != '0);
			wt_s1  <= w_pay.wt;

			tgt_s2 <= tgtp[23:0];
			o_s2   <= o_s1;
			ow_s2  <= ow_s1;
			lay_s2 <= lay_s1;
			tch_s2 <= tch_s1;
			wt_s2  <= wt_s1;

			for (int j = 0; j < 3; j++) begin
				m_s3[j] <= 17'((33'(ow_s2[j]) * 33'(tgt_s2) + {8'd0, o_s2, 15'd0}) >> 16);
			end
			o_s3   <= o_s2;
			lay_s3 <= lay_s2;
			tch_s3 <= tch_s2;
			wt_s3  <= wt_s2;
		end
	end

	// rescale each other layer: quotient of the rounded numerator by their sum
	for (genvar k = 0; k < BQ_W; k++) begin : g_div
		logic            v_in;
		logic [2:0][9:0] rem_in;
		logic [2:0][8:0] num_in;
		logic [2:0][8:0] q_in;
		logic [9:0]      o_in;
		logic [1:0]      lay_in;
		logic            tch_in;
		logic [3:0][7:0] wt_in;
		logic [2:0][9:0] rem_nx;
		logic [2:0][8:0] q_nx;

		if (k == 0) begin : g_first
			assign v_in = v_s3;
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign rem_in[j] = {2'b00, m_s3[j][16:9]};
				assign num_in[j] = m_s3[j][8:0];
			end
			assign q_in   = '0;
			assign o_in   = o_s3;
			assign lay_in = lay_s3;
			assign tch_in = tch_s3;
			assign wt_in  = wt_s3;
		end else begin : g_next
			assign v_in   = bd_v_s[k-1];
			assign rem_in = bd_rem_s[k-1];
			assign num_in = bd_num_s[k-1];
			assign q_in   = bd_q_s[k-1];
			assign o_in   = bd_o_s[k-1];
			assign lay_in = bd_lay_s[k-1];
			assign tch_in = bd_tch_s[k-1];
			assign wt_in  = bd_wt_s[k-1];
		end

		always_comb begin
			logic [10:0] sh;
			for (int j = 0; j < 3; j++) begin
				sh        = {rem_in[j], num_in[j][BQ_W-1-k]};
				q_nx[j]   = q_in[j];
				if (sh >= {1'b0, o_in}) begin
					rem_nx[j]              = 10'(sh - {1'b0, o_in});
					q_nx[j][BQ_W-1-k]      = 1'b1;
				end else begin
					rem_nx[j]              = sh[9:0];
					q_nx[j][BQ_W-1-k]      = 1'b0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bd_v_s[k] <= 1'b0;
			end else if (adv) begin
				bd_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				bd_rem_s[k] <= rem_nx;
				bd_num_s[k] <= num_in;
				bd_q_s[k]   <= q_nx;
				bd_o_s[k]   <= o_in;
				bd_lay_s[k] <= lay_in;
				bd_tch_s[k] <= tch_in;
				bd_wt_s[k]  <= wt_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [2:0][7:0] v;
		logic [9:0]      sum;
		logic [7:0]      painted;
		logic [1:0]      lay;
		if (adv) begin
			lay = bd_lay_s[BQ_W-1];
			sum = '0;
			for (int j = 0; j < 3; j++) begin
				if (bd_o_s[BQ_W-1] == '0) begin
					v[j] = '0;
				end else if (bd_q_s[BQ_W-1][j] > 9'd255) begin
					v[j] = 8'd255;
				end else begin
					v[j] = bd_q_s[BQ_W-1][j][7:0];
				end
				sum = sum + 10'(v[j]);
			end
			painted = (sum > 10'd255) ? 8'd0 : 8'(10'd255 - sum);
			res_s4.touched <= bd_tch_s[BQ_W-1];
			for (int i = 0; i < 4; i++) begin
				if (!bd_tch_s[BQ_W-1]) begin
					res_s4.wt[i] <= bd_wt_s[BQ_W-1][i];
				end else if (2'(i) == lay) begin
					res_s4.wt[i] <= painted;
				end else if (2'(i) < lay) begin
					res_s4.wt[i] <= v[2'(i)];
				end else begin
					res_s4.wt[i] <= v[2'(i - 1)];
				end
			end
		end
	end

	assign res_v = v_s4;
	assign res   = res_s4;

endmodule

// ===== rtl/core/swp_chk.sv =====
module swp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       texel_valid,
	input logic       texel_ready,
	input logic       paint_valid,
	input logic       paint_ready,
	input logic [7:0] out_weight0,
	input logic [7:0] out_weight1,
	input logic [7:0] out_weight2,
	input logic [7:0] out_weight3,
	input logic       touched
);

	logic [9:0] wsum;

	assign wsum = 10'(out_weight0) + 10'(out_weight1) + 10'(out_weight2) + 10'(out_weight3);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		paint_valid && !paint_ready |=> paint_valid &&
		$stable({out_weight0, out_weight1, out_weight2, out_weight3, touched}))
		else $error("result changed while stalled");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		paint_valid && touched |-> wsum >= 10'd255)
		else $error("painted weights fall short of full coverage");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!paint_valid |-> texel_ready)
		else $error("input held with empty output");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		paint_valid && !paint_ready |-> !texel_ready)
		else $error("input taken while pipe stalled");

endmodule

bind splat_weight_paint_core swp_chk u_swp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.texel_valid (texel.valid),
	.texel_ready (texel.ready),
	.paint_valid (paint.valid),
	.paint_ready (paint.ready),
	.out_weight0 (paint.out_weight0),
	.out_weight1 (paint.out_weight1),
	.out_weight2 (paint.out_weight2),
	.out_weight3 (paint.out_weight3),
	.touched     (paint.touched)
);
